### src/text_header_frame_parser_macros.svh
// Assertion helpers for the files that check their own logic; only text_header_frame_parser.sv includes them.
`ifndef TEXT_HEADER_FRAME_PARSER_MACROS_SVH
`define TEXT_HEADER_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define THFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("thfp assertion failed");

// Next-cycle implication, checked outside reset.
`define THFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("thfp assertion failed");

`endif

### src/thfp_pkg.sv
`default_nettype none

package thfp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [2:0] MAGIC_LAST = 3'd5;
    localparam logic [2:0] KEY_POS_MAX = 3'd7;

    // Key lanes: 0 Length, 1 Index, 2 Channel.
    localparam int NUM_KEYS = 3;
    localparam logic [7:0] KEY_TEXT [NUM_KEYS][8] = '{
        '{"L", "e", "n", "g", "t", "h", 8'h00, 8'h00},
        '{"I", "n", "d", "e", "x", 8'h00, 8'h00, 8'h00},
        '{"C", "h", "a", "n", "n", "e", "l", 8'h00}
    };
    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd6, 3'd5, 3'd7};

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_DATA   = 2'd1,
        EV_ERROR  = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        DS_SKIP   = 2'd0,
        DS_DIGITS = 2'd1,
        DS_DONE   = 2'd2
    } t_digit;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [7:0]  chan;
        logic [31:0] index;
        logic [31:0] len;
        logic        last;
    } t_result;

    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = "V";
            3'd1:    c = "1";
            3'd2:    c = ".";
            3'd3:    c = "0";
            3'd4:    c = CHAR_CR;
            3'd5:    c = CHAR_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### src/thfp_byte_if.sv
`default_nettype none

interface thfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

`default_nettype wire

### src/thfp_rec_if.sv
`default_nettype none

interface thfp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  channel;
    logic [31:0] seq_index;
    logic [31:0] content_length;
    logic        last;

    modport source (
        output valid, output event_res, output data_byte, output channel,
        output seq_index, output content_length, output last, input ready
    );
    modport sink (
        input valid, input event_res, input data_byte, input channel,
        input seq_index, input content_length, input last, output ready
    );
endinterface

`default_nettype wire

### src/thfp_digit_acc.sv
`default_nettype none

// One character of a decimal value: skip spaces, accumulate, saturate.
module thfp_digit_acc #(
    parameter int VALUE_WIDTH = thfp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic [VALUE_WIDTH-1:0] i_acc,
    input  wire thfp_pkg::t_digit       i_ds,
    input  wire logic [7:0]             i_char,
    output logic [VALUE_WIDTH-1:0]      o_acc,
    output thfp_pkg::t_digit            o_ds,
    output logic                        o_err
);

    logic                   w_is_digit;
    logic [3:0]             w_digit;
    logic [VALUE_WIDTH+3:0] w_prod;

    assign w_is_digit = (i_char >= thfp_pkg::CHAR_ZERO) && (i_char <= thfp_pkg::CHAR_NINE);
    assign w_digit    = 4'(i_char - thfp_pkg::CHAR_ZERO);
    // acc * 10 + d; any bit above the value width means saturation
    assign w_prod = {i_acc, 3'b000} + {2'b00, i_acc, 1'b0}
                  + (VALUE_WIDTH+4)'(w_digit);

    always_comb begin
        o_acc = i_acc;
        o_ds  = i_ds;
        o_err = 1'b0;
        unique case (i_ds)
            thfp_pkg::DS_SKIP: begin
                if (i_char != thfp_pkg::CHAR_SPACE) begin
                    if (!w_is_digit) begin
                        o_err = 1'b1;
                    end else begin
                        o_acc = VALUE_WIDTH'(w_digit);
                        o_ds  = thfp_pkg::DS_DIGITS;
                    end
                end
            end
            thfp_pkg::DS_DIGITS: begin
                if (w_is_digit) begin
                    o_acc = (|w_prod[VALUE_WIDTH+3:VALUE_WIDTH]) ? '1
                                                                 : w_prod[VALUE_WIDTH-1:0];
                end else begin
                    o_ds = thfp_pkg::DS_DONE;
                end
            end
            default: begin
                o_ds = i_ds;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/thfp_core.sv
`default_nettype none

// Parser state and per-byte next-state logic; one byte per advance.
module thfp_core #(
    parameter int VALUE_WIDTH = thfp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [7:0]        i_byte,
    output logic                   o_res_valid,
    output thfp_pkg::t_result      o_res
);

    localparam int AW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_KEY,
        PH_VALUE,
        PH_CONTENT,
        PH_ERROR
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_magic_pos, n_magic_pos;
    logic [2:0]             r_cand, n_cand;
    logic [2:0]             r_key_pos, n_key_pos;
    logic                   r_line_started, n_line_started;
    logic                   r_cr_pending, n_cr_pending;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    thfp_pkg::t_digit       r_ds, n_ds;
    logic [7:0]             r_chan, n_chan;
    logic [31:0]            r_index, n_index;
    logic [31:0]            r_len, n_len;
    logic [31:0]            r_bytes_left, n_bytes_left;

    // State after a pending CR that turned out to be an ordinary character
    logic                   w_line_end;
    logic [2:0]             w_pre_cand;
    logic [2:0]             w_pre_key_pos;
    logic                   w_pre_started;
    thfp_pkg::t_digit       w_pre_ds;
    logic                   w_pre_err;
    logic [2:0]             w_key_pos_inc;

    logic [VALUE_WIDTH-1:0] w_dg_acc;
    thfp_pkg::t_digit       w_dg_ds;
    logic                   w_dg_err;

    logic [AW-1:0]          w_acc_ext;
    logic [31:0]            w_acc_sat32;
    logic [7:0]             w_acc_sat8;
    logic [31:0]            w_bytes_dec;

    assign w_key_pos_inc = (r_key_pos == thfp_pkg::KEY_POS_MAX) ? r_key_pos : r_key_pos + 3'd1;
    assign w_acc_ext     = AW'(r_acc);
    assign w_acc_sat32   = (w_acc_ext > AW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_acc_ext[31:0];
    assign w_acc_sat8    = (w_acc_ext > AW'(8'hFF)) ? 8'hFF : w_acc_ext[7:0];
    assign w_bytes_dec   = (r_bytes_left != 32'd0) ? r_bytes_left - 32'd1 : 32'd0;

    always_comb begin
        w_line_end    = 1'b0;
        w_pre_cand    = r_cand;
        w_pre_key_pos = r_key_pos;
        w_pre_started = r_line_started;
        w_pre_ds      = r_ds;
        w_pre_err     = 1'b0;
        if (r_cr_pending) begin
            if (i_byte == thfp_pkg::CHAR_LF) begin
                w_line_end = 1'b1;
            end else if (r_phase == PH_KEY) begin
                // CR never matches a key character
                w_pre_started = 1'b1;
                w_pre_cand    = 3'b000;
                w_pre_key_pos = w_key_pos_inc;
            end else if (r_cand != 3'b000) begin
                if (r_ds == thfp_pkg::DS_SKIP) begin
                    w_pre_err = 1'b1;
                end else if (r_ds == thfp_pkg::DS_DIGITS) begin
                    w_pre_ds = thfp_pkg::DS_DONE;
                end
            end
        end
    end

    thfp_digit_acc #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_digit (
        .i_acc  (r_acc),
        .i_ds   (w_pre_ds),
        .i_char (i_byte),
        .o_acc  (w_dg_acc),
        .o_ds   (w_dg_ds),
        .o_err  (w_dg_err)
    );

    always_comb begin
        logic       err;
        logic       new_line;
        logic [2:0] hit;
        logic [2:0] kpos_next;

        n_phase        = r_phase;
        n_magic_pos    = r_magic_pos;
        n_cand         = r_cand;
        n_key_pos      = r_key_pos;
        n_line_started = r_line_started;
        n_cr_pending   = r_cr_pending;
        n_acc          = r_acc;
        n_ds           = r_ds;
        n_chan         = r_chan;
        n_index        = r_index;
        n_len          = r_len;
        n_bytes_left   = r_bytes_left;
        o_res_valid    = 1'b0;
        o_res          = '0;
        err            = 1'b0;
        new_line       = 1'b0;
        hit            = 3'b000;
        kpos_next      = w_key_pos_inc;

        if (i_advance) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (i_byte != thfp_pkg::magic_char(r_magic_pos)) begin
                        err = 1'b1;
                    end else if (r_magic_pos == thfp_pkg::MAGIC_LAST) begin
                        n_magic_pos = 3'd0;
                        n_phase     = PH_KEY;
                        new_line    = 1'b1;
                        n_chan      = 8'd0;
                        n_index     = 32'd0;
                        n_len       = 32'd0;
                    end else begin
                        n_magic_pos = r_magic_pos + 3'd1;
                    end
                end
                PH_KEY, PH_VALUE: begin
                    n_cr_pending = 1'b0;
                    if (w_line_end) begin
                        if (r_phase == PH_KEY) begin
                            if (r_line_started) begin
                                err = 1'b1;
                            end else begin
                                // Empty line closes the header block
                                o_res_valid    = 1'b1;
                                o_res.ev       = thfp_pkg::EV_HEADER;
                                o_res.chan     = r_chan;
                                o_res.index    = r_index;
                                o_res.len      = r_len;
                                o_res.last     = (r_len == 32'd0);
                                n_phase        = (r_len != 32'd0) ? PH_CONTENT : PH_MAGIC;
                                n_bytes_left   = r_len;
                                new_line       = 1'b1;
                            end
                        end else begin
                            if ((r_cand != 3'b000) && (r_ds == thfp_pkg::DS_SKIP)) begin
                                err = 1'b1;
                            end else begin
                                if (r_cand[0]) begin
                                    n_len = w_acc_sat32;
                                end
                                if (r_cand[1]) begin
                                    n_index = w_acc_sat32;
                                end
                                if (r_cand[2]) begin
                                    n_chan = w_acc_sat8;
                                end
                                n_phase  = PH_KEY;
                                new_line = 1'b1;
                            end
                        end
                    end else if (w_pre_err) begin
                        err = 1'b1;
                    end else begin
                        n_cand         = w_pre_cand;
                        n_key_pos      = w_pre_key_pos;
                        n_line_started = w_pre_started;
                        n_ds           = w_pre_ds;
                        if (w_pre_key_pos != r_key_pos) begin
                            kpos_next = (w_pre_key_pos == thfp_pkg::KEY_POS_MAX)
                                      ? w_pre_key_pos : w_pre_key_pos + 3'd1;
                        end
                        if (i_byte == thfp_pkg::CHAR_CR) begin
                            n_cr_pending = 1'b1;
                        end else if (r_phase == PH_KEY) begin
                            n_line_started = 1'b1;
                            if (i_byte == thfp_pkg::CHAR_COLON) begin
                                for (int k = 0; k < thfp_pkg::NUM_KEYS; k++) begin
                                    if (w_pre_cand[k]
                                        && (w_pre_key_pos == thfp_pkg::KEY_LEN[2'(k)])) begin
                                        hit[k] = 1'b1;
                                    end
                                end
                                n_cand  = hit;
                                n_phase = PH_VALUE;
                                n_ds    = thfp_pkg::DS_SKIP;
                                n_acc   = '0;
                            end else begin
                                for (int k = 0; k < thfp_pkg::NUM_KEYS; k++) begin
                                    if ((w_pre_key_pos >= thfp_pkg::KEY_LEN[2'(k)])
                                        || (thfp_pkg::KEY_TEXT[2'(k)][w_pre_key_pos]
                                            != i_byte)) begin
                                        n_cand[k] = 1'b0;
                                    end
                                end
                                n_key_pos = kpos_next;
                            end
                        end else if (w_pre_cand != 3'b000) begin
                            if (w_dg_err) begin
                                err = 1'b1;
                            end else begin
                                n_acc = w_dg_acc;
                                n_ds  = w_dg_ds;
                            end
                        end
                    end
                end
                PH_CONTENT: begin
                    o_res_valid  = 1'b1;
                    o_res.ev     = thfp_pkg::EV_DATA;
                    o_res.data   = i_byte;
                    o_res.chan   = r_chan;
                    o_res.index  = r_index;
                    o_res.len    = r_len;
                    n_bytes_left = w_bytes_dec;
                    if (w_bytes_dec == 32'd0) begin
                        o_res.last = 1'b1;
                        n_phase    = PH_MAGIC;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase

            if (new_line) begin
                n_cand         = 3'b111;
                n_key_pos      = 3'd0;
                n_line_started = 1'b0;
                n_cr_pending   = 1'b0;
                n_acc          = '0;
                n_ds           = thfp_pkg::DS_SKIP;
            end
            if (err) begin
                n_phase     = PH_ERROR;
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.ev    = thfp_pkg::EV_ERROR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_MAGIC;
            r_magic_pos    <= 3'd0;
            r_cand         <= 3'b111;
            r_key_pos      <= 3'd0;
            r_line_started <= 1'b0;
            r_cr_pending   <= 1'b0;
            r_acc          <= '0;
            r_ds           <= thfp_pkg::DS_SKIP;
            r_chan         <= 8'd0;
            r_index        <= 32'd0;
            r_len          <= 32'd0;
            r_bytes_left   <= 32'd0;
        end else begin
            r_phase        <= n_phase;
            r_magic_pos    <= n_magic_pos;
            r_cand         <= n_cand;
            r_key_pos      <= n_key_pos;
            r_line_started <= n_line_started;
            r_cr_pending   <= n_cr_pending;
            r_acc          <= n_acc;
            r_ds           <= n_ds;
            r_chan         <= n_chan;
            r_index        <= n_index;
            r_len          <= n_len;
            r_bytes_left   <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

### src/text_header_frame_parser.sv
// Channel   Dir  Modport  Payload
// i_byte    in   sink     byte_in[7:0]
// o_rec     out  source   event_res, data_byte, channel, seq_index, content_length, last
//
// One byte per cycle sustained while o_rec is not stalled; a byte that is taken passes
// through the input register, then parser logic into the result register.
// The parser state advances once per byte; the decimal accumulate
// (acc * 10 + digit) on the value path is combinational.
// i_rst_n is synchronous: parser returns to the magic line, counters clear.
// A stalled o_rec holds its record; i_byte keeps taking one more byte until the
// input register is also full.
`default_nettype none

`include "text_header_frame_parser_macros.svh"

module text_header_frame_parser #(
    parameter int VALUE_WIDTH = thfp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    thfp_byte_if.sink        i_byte,
    thfp_rec_if.source       o_rec
);

    // Input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // Result register
    logic              r_out_valid;
    thfp_pkg::t_result r_out;

    logic              w_advance;
    logic              w_res_valid;
    thfp_pkg::t_result w_res;

    // Check terms
    logic              w_rec_err;
    logic              w_rec_no_data;
    logic              w_held;

    // Advance the held byte whenever the result register is free or draining
    assign w_advance    = r_in_valid && (!r_out_valid || o_rec.ready);
    assign i_byte.ready = !r_in_valid || w_advance;

    thfp_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Hold the byte until the parser takes it
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            // Load a new record, or drop the delivered one
            if (w_advance && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_rec.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_rec.valid          = r_out_valid;
    assign o_rec.event_res      = r_out.ev;
    assign o_rec.data_byte      = r_out.data;
    assign o_rec.channel        = r_out.chan;
    assign o_rec.seq_index      = r_out.index;
    assign o_rec.content_length = r_out.len;
    assign o_rec.last           = r_out.last;

    assign w_rec_err     = o_rec.valid && (o_rec.event_res == 2'(thfp_pkg::EV_ERROR));
    assign w_rec_no_data = o_rec.valid && (o_rec.event_res != 2'(thfp_pkg::EV_DATA));
    assign w_held        = r_in_valid && r_out_valid && !o_rec.ready;

    // Errors are sticky: once an error record shows, every later record is one too.
    `THFP_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, w_rec_err, !o_rec.valid || w_rec_err)
    // An error record never carries a last mark.
    `THFP_ASSERT_NOW(a_last_not_error, i_clk, i_rst_n, o_rec.valid && o_rec.last, !w_rec_err)
    // Only content records carry a data byte.
    `THFP_ASSERT_NOW(a_data_only_content, i_clk, i_rst_n, w_rec_no_data, o_rec.data_byte == 8'd0)
    // A full input register behind a stalled result blocks the input side.
    `THFP_ASSERT_NOW(a_full_blocks_input, i_clk, i_rst_n, w_held, !i_byte.ready)

endmodule

`default_nettype wire

### tb/text_header_frame_parser_tb.sv
`default_nettype none

// Byte-stream deframer bench: feed packets (magic line, header lines, blank
// line, content), predict each record in lockstep with every accepted byte
// transaction, and check records in order on the output channel.
module text_header_frame_parser_tb;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 300;
    localparam int IDLE_PCT     = 15;
    localparam int QUIET_FROM   = 300;   // no idling on either side in this window
    localparam int QUIET_TO     = 550;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0]  MAGIC_TAIL = 3'd5;
    localparam logic [2:0]  KEY_SAT    = 3'd7;
    localparam logic [63:0] ACC_MAX    = {64{1'b1}} >> (64 - thfp_pkg::VALUE_WIDTH_DEF);
    localparam logic [63:0] U32_MAX    = 64'hFFFF_FFFF;
    localparam logic [63:0] U8_MAX     = 64'hFF;

    // Key lanes, one bit each in the live-candidate mask.
    localparam int LANE_LENGTH  = 0;
    localparam int LANE_INDEX   = 1;
    localparam int LANE_CHANNEL = 2;
    localparam int NUM_LANES    = 3;

    typedef enum logic [2:0] {
        PS_MAGIC,
        PS_KEY,
        PS_VALUE,
        PS_CONTENT,
        PS_ERROR
    } t_parse_phase;

    typedef enum logic [1:0] {
        FAIL_MAGIC,
        FAIL_NO_COLON,
        FAIL_EMPTY_VALUE
    } t_failure;

    logic clk;
    logic rst_n;
    int   cyc = 0;

    thfp_byte_if byte_bus ();
    thfp_rec_if  rec_bus ();

    text_header_frame_parser u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_bus),
        .o_rec   (rec_bus)
    );

    logic [7:0]        stream_q[$];      // bytes still to be offered
    thfp_pkg::t_result due_records[$];   // predicted records, oldest first
    int                total_bytes = 0;
    int                bytes_taken = 0;
    int                bad_records = 0;

    // Shadow parser state.
    t_parse_phase     ph;
    logic [2:0]       magic_at;
    logic [2:0]       lanes;
    logic [2:0]       key_at;
    logic             line_busy;
    logic             cr_seen;
    logic [63:0]      acc;
    thfp_pkg::t_digit dig;
    logic [7:0]       chan_q;
    logic [31:0]      index_q;
    logic [31:0]      length_q;
    logic [31:0]      remain;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) cyc <= cyc + 1;

    function automatic string key_name(input int lane);
        case (lane)
            LANE_LENGTH: return "Length";
            LANE_INDEX:  return "Index";
            default:     return "Channel";
        endcase
    endfunction

    function automatic logic [7:0] magic_byte(input int pos);
        case (pos)
            0:       return "V";
            1:       return "1";
            2:       return ".";
            3:       return "0";
            4:       return thfp_pkg::CHAR_CR;
            default: return thfp_pkg::CHAR_LF;
        endcase
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= thfp_pkg::CHAR_ZERO && c <= thfp_pkg::CHAR_NINE;
    endfunction

    // Hold both sides busy through the quiet window; elsewhere idle at random.
    function automatic bit take_break();
        return !(cyc >= QUIET_FROM && cyc < QUIET_TO)
               && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------
    function automatic void clear_line();
        lanes     = 3'b111;
        key_at    = '0;
        line_busy = 1'b0;
        cr_seen   = 1'b0;
        acc       = '0;
        dig       = thfp_pkg::DS_SKIP;
    endfunction

    function automatic void reset_parser();
        ph       = PS_MAGIC;
        magic_at = '0;
        clear_line();
        chan_q   = '0;
        index_q  = '0;
        length_q = '0;
        remain   = '0;
    endfunction

    // Errors are sticky: park the parser and emit an all-zero error record.
    function automatic thfp_pkg::t_result enter_error();
        thfp_pkg::t_result rec;
        rec    = '0;
        rec.ev = thfp_pkg::EV_ERROR;
        ph     = PS_ERROR;
        return rec;
    endfunction

    // One header character that is not part of a line end. Returns 0 on error.
    function automatic bit header_char(input logic [7:0] c);
        logic [2:0]  hit;
        logic [63:0] d;
        string       nm;
        if (ph == PS_KEY) begin
            line_busy = 1'b1;
            if (c == thfp_pkg::CHAR_COLON) begin
                // A key survives only if every character matched and it is complete.
                hit = '0;
                for (int k = 0; k < NUM_LANES; k++) begin
                    nm = key_name(k);
                    if (lanes[k] && key_at == nm.len()) hit = 3'b001 << k;
                end
                lanes = hit;
                ph    = PS_VALUE;
                dig   = thfp_pkg::DS_SKIP;
                acc   = '0;
            end else begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    nm = key_name(k);
                    if (key_at >= nm.len() || nm[key_at] != c) lanes[k] = 1'b0;
                end
                if (key_at != KEY_SAT) key_at = key_at + 3'd1;
            end
            return 1'b1;
        end
        // Unknown key: the value is never looked at.
        if (lanes == '0) return 1'b1;
        d = {56'd0, c - thfp_pkg::CHAR_ZERO};
        case (dig)
            thfp_pkg::DS_SKIP: begin
                if (c == thfp_pkg::CHAR_SPACE) return 1'b1;
                if (!is_digit(c)) return 1'b0;
                acc = d;
                dig = thfp_pkg::DS_DIGITS;
            end
            thfp_pkg::DS_DIGITS: begin
                if (!is_digit(c)) dig = thfp_pkg::DS_DONE;
                else if (acc > (ACC_MAX - d) / 10) acc = ACC_MAX;
                else acc = acc * 10 + d;
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    // CR LF: close a header line, or the header block on an empty line.
    function automatic bit header_line_end(output thfp_pkg::t_result rec);
        rec = '0;
        if (ph == PS_KEY) begin
            if (line_busy) begin
                rec = enter_error();
                return 1'b1;
            end
            rec.ev    = thfp_pkg::EV_HEADER;
            rec.chan  = chan_q;
            rec.index = index_q;
            rec.len   = length_q;
            rec.last  = (length_q == '0);
            if (length_q != '0) begin
                ph     = PS_CONTENT;
                remain = length_q;
            end else begin
                ph = PS_MAGIC;
            end
            clear_line();
            return 1'b1;
        end
        if (lanes != '0) begin
            if (dig == thfp_pkg::DS_SKIP) begin
                rec = enter_error();
                return 1'b1;
            end
            if (lanes[LANE_LENGTH])  length_q = (acc > U32_MAX) ? '1 : acc[31:0];
            if (lanes[LANE_INDEX])   index_q  = (acc > U32_MAX) ? '1 : acc[31:0];
            if (lanes[LANE_CHANNEL]) chan_q   = (acc > U8_MAX) ? '1 : acc[7:0];
        end
        ph = PS_KEY;
        clear_line();
        return 1'b0;
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a record results.
    function automatic bit deframe_byte(input logic [7:0] b,
                                        output thfp_pkg::t_result rec);
        rec = '0;
        case (ph)
            PS_MAGIC: begin
                if (b != magic_byte(magic_at)) begin
                    rec = enter_error();
                    return 1'b1;
                end
                if (magic_at == MAGIC_TAIL) begin
                    // Magic line done: a fresh packet starts with cleared header values.
                    magic_at = '0;
                    ph       = PS_KEY;
                    clear_line();
                    chan_q   = '0;
                    index_q  = '0;
                    length_q = '0;
                end else begin
                    magic_at = magic_at + 3'd1;
                end
                return 1'b0;
            end
            PS_KEY, PS_VALUE: begin
                if (cr_seen) begin
                    cr_seen = 1'b0;
                    if (b == thfp_pkg::CHAR_LF) return header_line_end(rec);
                    // A lone CR is an ordinary character.
                    if (!header_char(thfp_pkg::CHAR_CR)) begin
                        rec = enter_error();
                        return 1'b1;
                    end
                end
                if (b == thfp_pkg::CHAR_CR) begin
                    cr_seen = 1'b1;
                    return 1'b0;
                end
                if (!header_char(b)) begin
                    rec = enter_error();
                    return 1'b1;
                end
                return 1'b0;
            end
            PS_CONTENT: begin
                rec.ev    = thfp_pkg::EV_DATA;
                rec.data  = b;
                rec.chan  = chan_q;
                rec.index = index_q;
                rec.len   = length_q;
                if (remain != '0) remain = remain - 32'd1;
                if (remain == '0) begin
                    rec.last = 1'b1;
                    ph       = PS_MAGIC;
                end
                return 1'b1;
            end
            default: begin
                rec = enter_error();
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    function automatic logic [7:0] loose_byte(input bit no_colon, input bit no_lf);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == thfp_pkg::CHAR_CR || (no_colon && b == thfp_pkg::CHAR_COLON)
               || (no_lf && b == thfp_pkg::CHAR_LF));
        return b;
    endfunction

    // A byte that stops a decimal value: never a digit, never a CR.
    function automatic logic [7:0] stray_byte(input bit no_space);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (is_digit(b) || b == thfp_pkg::CHAR_CR
               || (no_space && b == thfp_pkg::CHAR_SPACE));
        return b;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_crlf();
        put_byte(thfp_pkg::CHAR_CR);
        put_byte(thfp_pkg::CHAR_LF);
    endtask

    task automatic put_magic();
        for (int p = 0; p <= MAGIC_TAIL; p++) put_byte(magic_byte(p));
    endtask

    task automatic put_tail(input int n, input bit no_colon);
        repeat (n) put_byte(loose_byte(no_colon, 1'b0));
    endtask

    task automatic put_digits(input int n);
        repeat (n) put_byte(thfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Trailing junk after the digits; a lone CR must not be followed by LF here.
    task automatic put_suffix();
        case ($urandom_range(0, 5))
            3: begin
                put_byte(stray_byte(1'b0));
                put_tail($urandom_range(0, 4), 1'b0);
            end
            4: begin
                put_byte(thfp_pkg::CHAR_CR);
                put_byte(loose_byte(1'b0, 1'b1));
                put_tail($urandom_range(0, 4), 1'b0);
            end
            5: put_text(" ms");
            default: ;
        endcase
    endtask

    task automatic put_keyed_line(input string key, input logic [63:0] num, input bit huge);
        put_text(key);
        put_byte(thfp_pkg::CHAR_COLON);
        repeat ($urandom_range(0, 3)) put_byte(thfp_pkg::CHAR_SPACE);
        if ($urandom_range(0, 3) == 0) put_byte(thfp_pkg::CHAR_ZERO);
        if (huge) put_digits($urandom_range(11, 24));
        else put_text($sformatf("%0d", num));
        put_suffix();
        put_crlf();
    endtask

    // Lines whose key matches nothing: near misses, lone CR, empty and random keys.
    task automatic put_other_line();
        case ($urandom_range(0, 7))
            0: put_text("Len");
            1: put_text("Lengthy");
            2: put_text("length");
            3: put_text("Index ");
            4: put_text("Channel2");
            5: begin
                put_text("Len");
                put_byte(thfp_pkg::CHAR_CR);
                put_text("gth");
            end
            6: ;
            default: begin
                put_byte("X");
                put_tail($urandom_range(0, 9), 1'b1);
            end
        endcase
        put_byte(thfp_pkg::CHAR_COLON);
        put_tail($urandom_range(0, 8), 1'b0);
        put_crlf();
    endtask

    task automatic put_random_line(input bit decoy_ok);
        logic [63:0] v;
        bit          huge;
        huge = 1'b0;
        case ($urandom_range(0, 6))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0:       v = $urandom_range(0, 9);
                    1:       v = U32_MAX;
                    2:       v = U32_MAX + 64'd1;
                    3:       huge = 1'b1;
                    default: v = $urandom;
                endcase
                put_keyed_line("Index", v, huge);
            end
            2, 3: begin
                case ($urandom_range(0, 4))
                    0:       v = U8_MAX;
                    1:       v = U8_MAX + 64'd1;
                    2:       huge = 1'b1;
                    3:       v = $urandom_range(256, 100000);
                    default: v = $urandom_range(0, 255);
                endcase
                put_keyed_line("Channel", v, huge);
            end
            // An earlier Length line, overridden by the one that sets the content size.
            4: begin
                if (decoy_ok) put_keyed_line("Length", $urandom, $urandom_range(0, 1));
                else put_other_line();
            end
            default: put_other_line();
        endcase
    endtask

    task automatic put_packet();
        int pick;
        int plen;
        int n_lines;
        int real_at;
        pick = $urandom_range(0, 99);
        if (pick < 15) plen = 0;
        else if (pick < 75) plen = $urandom_range(1, 6);
        else plen = $urandom_range(7, 40);
        n_lines = $urandom_range(0, 5);
        // Zero length may also come from the Length line being absent.
        real_at = (plen == 0 && $urandom_range(0, 1)) ? -1 : $urandom_range(0, n_lines);
        put_magic();
        for (int i = 0; i <= n_lines; i++) begin
            if (i == real_at) put_keyed_line("Length", plen, 1'b0);
            if (i < n_lines) put_random_line(i < real_at);
        end
        put_crlf();
        repeat (plen) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic put_directed();
        // Value extremes that fit, one content byte of all zeros.
        put_magic();
        put_text("Length:1");
        put_crlf();
        put_text("Index:4294967295");
        put_crlf();
        put_text("Channel:255");
        put_crlf();
        put_crlf();
        put_byte(8'h00);
        // Saturation, repeated Length, trailing junk after digits.
        put_magic();
        put_text("Channel:256");
        put_crlf();
        put_text("Index:4294967296");
        put_crlf();
        put_text("Length:99999999999");
        put_crlf();
        put_text("Length:  02 ms");
        put_crlf();
        put_crlf();
        put_byte(8'hFF);
        put_byte(thfp_pkg::CHAR_CR);
        // Zero length, case mismatch, empty key, CR spoiling a key, CR ending a value.
        put_magic();
        put_text("length:5");
        put_crlf();
        put_text(":");
        put_crlf();
        put_text("Len");
        put_byte(thfp_pkg::CHAR_CR);
        put_text("gth:7");
        put_crlf();
        put_text("Index:8");
        put_byte(thfp_pkg::CHAR_CR);
        put_text("9");
        put_crlf();
        put_text("Channel:   7");
        put_crlf();
        put_crlf();
    endtask

    // Errors stick until reset, so exactly one failure closes the stream.
    task automatic put_failure();
        int at;
        case (t_failure'($urandom_range(0, 2)))
            FAIL_MAGIC: begin
                at = $urandom_range(0, MAGIC_TAIL);
                for (int p = 0; p < at; p++) put_byte(magic_byte(p));
                put_byte(magic_byte(at) ^ 8'($urandom_range(1, 255)));
            end
            FAIL_NO_COLON: begin
                put_magic();
                repeat ($urandom_range(1, 6)) put_byte(loose_byte(1'b1, 1'b0));
                put_crlf();
            end
            default: begin
                put_magic();
                put_text(key_name($urandom_range(0, NUM_LANES - 1)));
                put_byte(thfp_pkg::CHAR_COLON);
                repeat ($urandom_range(0, 2)) put_byte(thfp_pkg::CHAR_SPACE);
                case ($urandom_range(0, 2))
                    0: put_crlf();
                    1: put_byte(stray_byte(1'b1));
                    default: begin
                        put_byte(thfp_pkg::CHAR_CR);
                        put_byte(loose_byte(1'b0, 1'b1));
                    end
                endcase
            end
        endcase
        // Every later byte must keep reporting the error.
        repeat ($urandom_range(3, 6)) put_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next byte once the previous transaction completed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            byte_bus.valid <= 1'b0;
        end else if (!byte_bus.valid || byte_bus.ready) begin
            if (stream_q.size() != 0 && !take_break()) begin
                byte_bus.valid   <= 1'b1;
                byte_bus.byte_in <= stream_q.pop_front();
            end else begin
                byte_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check the record transaction first, then predict from the
    // byte transaction of the same edge (a byte never returns that fast).
    // ------------------------------------------------------------------
    task automatic flag_record(input string why, input thfp_pkg::t_result want,
                               input thfp_pkg::t_result got);
        bad_records++;
        if (bad_records <= MAX_REPORTS)
            $display({"cycle %0d %s: want ev=%0d data=%02h chan=%0d index=%0d len=%0d",
                      " last=%0b, got ev=%0d data=%02h chan=%0d index=%0d len=%0d last=%0b"},
                     cyc, why, want.ev, want.data, want.chan, want.index, want.len,
                     want.last, got.ev, got.data, got.chan, got.index, got.len, got.last);
    endtask

    always @(posedge clk) begin
        thfp_pkg::t_result got;
        thfp_pkg::t_result want;
        if (!rst_n) begin
            rec_bus.ready <= 1'b0;
        end else begin
            if (rec_bus.valid && rec_bus.ready) begin
                got.ev    = thfp_pkg::t_event'(rec_bus.event_res);
                got.data  = rec_bus.data_byte;
                got.chan  = rec_bus.channel;
                got.index = rec_bus.seq_index;
                got.len   = rec_bus.content_length;
                got.last  = rec_bus.last;
                if (due_records.size() == 0) begin
                    flag_record("record with none pending", '0, got);
                end else begin
                    want = due_records.pop_front();
                    if (got.ev !== want.ev || got.data !== want.data || got.chan !== want.chan ||
                        got.index !== want.index || got.len !== want.len ||
                        got.last !== want.last)
                        flag_record("record mismatch", want, got);
                end
            end
            if (byte_bus.valid && byte_bus.ready) begin
                if (deframe_byte(byte_bus.byte_in, want)) due_records = {due_records, want};
                bytes_taken++;
            end
            rec_bus.ready <= !take_break();
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stream, release reset, drain, report.
    // ------------------------------------------------------------------
    initial begin
        int directed_bytes;
        rst_n <= 1'b0;
        reset_parser();

        put_directed();
        directed_bytes = stream_q.size();
        while (stream_q.size() - directed_bytes < RANDOM_BYTES) put_packet();
        put_failure();
        total_bytes = stream_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte transaction and every predicted record, bounded by the limit.
        while ((bytes_taken < total_bytes || due_records.size() != 0) && cyc < CYCLE_LIMIT)
            @(negedge clk);
        // Keep draining so a stray extra record still gets caught.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (cyc < CYCLE_LIMIT && bad_records == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
